### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check with reset masking
`define OFB_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frame builder check failed");

// check that also runs through reset
`define OFB_CHECK_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frame builder reset check failed");

`endif

### rtl/ofb_pkg.sv
// ----------------------------------------------------------------------------
// ofb_pkg
// Types, constants and helpers shared by the frame builder modules.
// ----------------------------------------------------------------------------
package ofb_pkg;

  typedef enum logic [1:0] {
    MODE_FACE  = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_VIEW  = 2'd2,
    MODE_IDENT = 2'd3
  } mode_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int SQ_STEPS   = 32;
  localparam int DIV_STEPS  = 17;
  localparam int NORM_TOP   = 30;

  localparam logic [16:0] POLE_RESET = 17'd64880;
  localparam logic [17:0] ONE_Q16    = 18'd65536;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][63:0] vec64_t;
  typedef logic [2:0][17:0] vec18_t;

  typedef struct packed {
    mode_t  mode;
    vec32_t org;
    vec32_t up;
    vec18_t a1;
  } ctx_t;

  typedef struct packed {
    ctx_t   ctx;
    vec64_t t;
  } job_t;

  typedef struct packed {
    ctx_t       ctx;
    logic [2:0] neg;
    logic       zero;
  } nsb_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] sx18(input logic [17:0] v);
    return {{14{v[17]}}, v};
  endfunction

endpackage

### rtl/ofb_if.sv
// ----------------------------------------------------------------------------
// ofb_if
// Valid/ready channels for frame requests and finished frames.
// ----------------------------------------------------------------------------
interface ofb_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  mode;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;

  modport source (output valid, mode, first_x, first_y, first_z, second_x, second_y,
                  second_z, up_x, up_y, up_z, input ready);
  modport sink   (input valid, mode, first_x, first_y, first_z, second_x, second_y,
                  second_z, up_x, up_y, up_z, output ready);
endinterface

interface ofb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] x_axis_x;
  logic signed [31:0] x_axis_y;
  logic signed [31:0] x_axis_z;
  logic signed [31:0] y_axis_x;
  logic signed [31:0] y_axis_y;
  logic signed [31:0] y_axis_z;
  logic signed [31:0] z_axis_x;
  logic signed [31:0] z_axis_y;
  logic signed [31:0] z_axis_z;

  modport source (output valid, origin_x, origin_y, origin_z, x_axis_x, x_axis_y,
                  x_axis_z, y_axis_x, y_axis_y, y_axis_z, z_axis_x, z_axis_y,
                  z_axis_z, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, x_axis_x, x_axis_y,
                  x_axis_z, y_axis_x, y_axis_y, y_axis_z, z_axis_x, z_axis_y,
                  z_axis_z, output ready);
endinterface

### rtl/orthonormal_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// orthonormal_frame_builder_unit
// Builds a right-handed Q16.16 frame (origin and three unit axes) per request.
//
//   channel   dir  handshake       contents
//   in_chan   in   valid/ready     mode, first, second and up vectors
//   out_chan  out  valid/ready     origin, X, Y and Z axes
//   cfg_*     in   write enable    pole threshold, unsigned Q1.16, 17 bits
//
// One request per cycle sustained while results are taken; the two pipelined
// normalizers (32 root steps, 17 divide steps each) make up most of the path.
// Synchronous reset empties the queue and all pipeline valids; threshold
// returns to 0.99. A stalled result holds the whole pipeline; the four-entry
// queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module orthonormal_frame_builder_unit (
  input  logic        clk,
  input  logic        rst_n,
  ofb_in_if.sink      in_chan,
  ofb_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);
  import ofb_pkg::*;

  logic [16:0] pole_thr_r, pole_thr_nxt;
  logic        push, pop;
  job_t        push_job, head;
  q_stat_t     stat;

  assign pole_thr_nxt = cfg_we ? cfg_wdata : pole_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_thr_r <= POLE_RESET;
    end else begin
      pole_thr_r <= pole_thr_nxt;
    end
  end

  ofb_front u_front (
    .in_chan  (in_chan),
    .stat     (stat),
    .push     (push),
    .push_job (push_job)
  );

  ofb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  ofb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pole_thr (pole_thr_r),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  `OFB_CHECK_NR(a_reset_idle, $past(!rst_n) |-> !out_chan.valid)
  `OFB_CHECK(a_x_unit, out_chan.valid |-> (out_chan.x_axis_x <= 32'sd65536 && out_chan.x_axis_x >= -32'sd65536 && out_chan.x_axis_y <= 32'sd65536 && out_chan.x_axis_y >= -32'sd65536))
  `OFB_CHECK(a_z_unit, out_chan.valid |-> (out_chan.z_axis_z <= 32'sd65536 && out_chan.z_axis_z >= -32'sd65536 && out_chan.z_axis_y <= 32'sd65536 && out_chan.z_axis_y >= -32'sd65536))
endmodule

### rtl/ofb_fifo.sv
// ----------------------------------------------------------------------------
// ofb_fifo
// Short job queue between the request classifier and the frame pipeline.
// ----------------------------------------------------------------------------
module ofb_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ofb_pkg::job_t    push_job,
  input  logic             pop,
  output ofb_pkg::job_t    head,
  output ofb_pkg::q_stat_t stat
);
  import ofb_pkg::*;

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign stat.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (FIFO_AW)'(push);
    rd_ptr_nxt = rd_ptr_r + (FIFO_AW)'(pop);
    count_nxt  = count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end
endmodule

### rtl/ofb_front.sv
// ----------------------------------------------------------------------------
// ofb_front
// Accepts frame requests, picks the origin and the first direction per mode.
// ----------------------------------------------------------------------------
module ofb_front (
  ofb_in_if.sink           in_chan,
  input  ofb_pkg::q_stat_t stat,
  output logic             push,
  output ofb_pkg::job_t    push_job
);
  import ofb_pkg::*;

  logic signed [63:0] dx, dy, dz;
  mode_t              mode;

  assign in_chan.ready = !stat.full;
  assign push          = in_chan.valid && !stat.full;
  assign mode          = mode_t'(in_chan.mode);

  assign dx = 64'(in_chan.second_x) - 64'(in_chan.first_x);
  assign dy = 64'(in_chan.second_y) - 64'(in_chan.first_y);
  assign dz = 64'(in_chan.second_z) - 64'(in_chan.first_z);

  always_comb begin
    push_job.ctx.mode = mode;
    push_job.ctx.up   = {in_chan.up_z, in_chan.up_y, in_chan.up_x};
    push_job.ctx.a1   = '0;
    push_job.ctx.org  = {in_chan.first_z, in_chan.first_y, in_chan.first_x};
    push_job.t        = '0;
    case (mode)
      MODE_FACE: begin
        push_job.ctx.org = {in_chan.second_z, in_chan.second_y, in_chan.second_x};
        push_job.t = {64'(in_chan.first_z), 64'(in_chan.first_y), 64'(in_chan.first_x)};
      end
      MODE_EDGE: begin
        push_job.t = {dz, dy, dx};
      end
      MODE_VIEW: begin
        push_job.ctx.org = {in_chan.second_z, in_chan.second_y, in_chan.second_x};
        push_job.t = {dz, dy, dx};
      end
      default: begin
        push_job.t = '0;
      end
    endcase
  end
endmodule

### rtl/ofb_norm.sv
// ----------------------------------------------------------------------------
// ofb_norm
// Pipelined vector normalizer: scale, root, then three divides to signed Q1.16.
// ----------------------------------------------------------------------------
module ofb_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  ofb_pkg::ctx_t   in_ctx,
  input  ofb_pkg::vec64_t in_c,
  output logic            out_valid,
  output ofb_pkg::ctx_t   out_ctx,
  output ofb_pkg::vec18_t out_u,
  output logic            out_nz
);
  import ofb_pkg::*;

  // magnitude stage
  logic             a_v_r;
  ctx_t             a_ctx_r;
  logic [2:0]       a_neg_r;
  logic [2:0][63:0] a_m_r;
  logic [63:0]      a_or_r;
  // byte scan stage
  logic             b_v_r;
  ctx_t             b_ctx_r;
  logic [2:0]       b_neg_r;
  logic [2:0][63:0] b_m_r;
  logic [7:0]       b_grp_r;
  logic [7:0][2:0]  b_lp_r;
  // leading one stage
  logic             c_v_r;
  nsb_t             c_sb_r;
  logic [2:0][63:0] c_m_r;
  logic [5:0]       c_pos_r;
  // scaled stage
  logic             d_v_r;
  nsb_t             d_sb_r;
  logic [2:0][30:0] d_mm_r;
  // square stage
  logic             e_v_r;
  nsb_t             e_sb_r;
  logic [2:0][30:0] e_mm_r;
  logic [2:0][61:0] e_sq_r;
  // root stages
  logic             sq_v_r    [0:SQ_STEPS];
  nsb_t             sq_sb_r   [0:SQ_STEPS];
  logic [2:0][30:0] sq_mm_r   [0:SQ_STEPS];
  logic [63:0]      sq_rem_r  [0:SQ_STEPS];
  logic [63:0]      sq_root_r [0:SQ_STEPS];
  // divide stages
  logic             dv_v_r    [0:DIV_STEPS];
  nsb_t             dv_sb_r   [0:DIV_STEPS];
  logic [31:0]      dv_len_r  [0:DIV_STEPS];
  logic [2:0][48:0] dv_rem_r  [0:DIV_STEPS];
  logic [2:0][16:0] dv_q_r    [0:DIV_STEPS];
  // result
  logic             h_v_r;
  nsb_t             h_sb_r;
  vec18_t           h_u_r;

  logic [2:0][63:0] a_m_nxt;
  logic [7:0]       b_grp_nxt;
  logic [7:0][2:0]  b_lp_nxt;
  logic [5:0]       c_pos_nxt;
  logic [2:0][30:0] d_mm_nxt;
  logic [31:0]      len;
  vec18_t           h_u_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_m_nxt[i] = in_c[i][63] ? 64'(-in_c[i]) : in_c[i];
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      b_grp_nxt[j] = |a_or_r[8*j +: 8];
      b_lp_nxt[j]  = '0;
      for (int k = 0; k < 8; k++) begin
        if (a_or_r[8*j + k]) begin
          b_lp_nxt[j] = 3'(k);
        end
      end
    end
  end

  always_comb begin
    c_pos_nxt = '0;
    for (int j = 0; j < 8; j++) begin
      if (b_grp_r[j]) begin
        c_pos_nxt = {3'(j), b_lp_r[j]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (c_pos_r >= 6'(NORM_TOP)) begin
        d_mm_nxt[i] = 31'(c_m_r[i] >> (c_pos_r - 6'(NORM_TOP)));
      end else begin
        d_mm_nxt[i] = 31'(c_m_r[i] << (6'(NORM_TOP) - c_pos_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      sq_v_r[0] <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctx_r <= in_ctx;
      a_neg_r <= {in_c[2][63], in_c[1][63], in_c[0][63]};
      a_m_r   <= a_m_nxt;
      a_or_r  <= a_m_nxt[0] | a_m_nxt[1] | a_m_nxt[2];

      b_ctx_r <= a_ctx_r;
      b_neg_r <= a_neg_r;
      b_m_r   <= a_m_r;
      b_grp_r <= b_grp_nxt;
      b_lp_r  <= b_lp_nxt;

      c_sb_r.ctx  <= b_ctx_r;
      c_sb_r.neg  <= b_neg_r;
      c_sb_r.zero <= ~|b_grp_r;
      c_m_r       <= b_m_r;
      c_pos_r     <= c_pos_nxt;

      d_sb_r <= c_sb_r;
      d_mm_r <= d_mm_nxt;

      e_sb_r <= d_sb_r;
      e_mm_r <= d_mm_r;
      for (int i = 0; i < 3; i++) begin
        e_sq_r[i] <= 62'(d_mm_r[i]) * 62'(d_mm_r[i]);
      end

      sq_sb_r[0]   <= e_sb_r;
      sq_mm_r[0]   <= e_mm_r;
      sq_rem_r[0]  <= 64'(e_sq_r[0]) + 64'(e_sq_r[1]) + 64'(e_sq_r[2]);
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    assign trial = sq_root_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_sb_r[k+1] <= sq_sb_r[k];
        sq_mm_r[k+1] <= sq_mm_r[k];
        if (sq_rem_r[k] >= trial) begin
          sq_rem_r[k+1]  <= sq_rem_r[k] - trial;
          sq_root_r[k+1] <= (sq_root_r[k] >> 1) + BIT;
        end else begin
          sq_rem_r[k+1]  <= sq_rem_r[k];
          sq_root_r[k+1] <= sq_root_r[k] >> 1;
        end
      end
    end
  end

  assign len = sq_root_r[SQ_STEPS][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sb_r[0]  <= sq_sb_r[SQ_STEPS];
      dv_len_r[0] <= len;
      dv_q_r[0]   <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= {2'b00, sq_mm_r[SQ_STEPS][i], 16'h0000} + 49'(len[31:1]);
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - k;
    logic [48:0] dsub;
    assign dsub = 49'(dv_len_r[k]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sb_r[k+1]  <= dv_sb_r[k];
        dv_len_r[k+1] <= dv_len_r[k];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_r[k][i] >= dsub) begin
            dv_rem_r[k+1][i] <= dv_rem_r[k][i] - dsub;
            dv_q_r[k+1][i]   <= dv_q_r[k][i] | (17'd1 << SH);
          end else begin
            dv_rem_r[k+1][i] <= dv_rem_r[k][i];
            dv_q_r[k+1][i]   <= dv_q_r[k][i];
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_sb_r[DIV_STEPS].zero) begin
        h_u_nxt[i] = '0;
      end else if (dv_sb_r[DIV_STEPS].neg[i]) begin
        h_u_nxt[i] = 18'(-{1'b0, dv_q_r[DIV_STEPS][i]});
      end else begin
        h_u_nxt[i] = {1'b0, dv_q_r[DIV_STEPS][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_sb_r <= dv_sb_r[DIV_STEPS];
      h_u_r  <= h_u_nxt;
    end
  end

  assign out_valid = h_v_r;
  assign out_ctx   = h_sb_r.ctx;
  assign out_u     = h_u_r;
  assign out_nz    = !h_sb_r.zero;
endmodule

### rtl/ofb_back.sv
// ----------------------------------------------------------------------------
// ofb_back
// Frame pipeline: first axis, helper cross, second axis, Y cross, result.
// ----------------------------------------------------------------------------
module ofb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [16:0]      pole_thr,
  input  ofb_pkg::job_t    head,
  input  ofb_pkg::q_stat_t stat,
  output logic             pop,
  ofb_out_if.source        out_chan
);
  import ofb_pkg::*;

  logic   en;
  logic   n1_v, n2_v, n1_nz, n2_nz;
  ctx_t   n1_ctx, n2_ctx;
  vec18_t n1_u, n2_u;

  // axis select / helper operands
  logic   p_v_r;
  ctx_t   p_ctx_r;
  vec32_t p_a_r, p_b_r;
  // helper cross products
  logic             x1_v_r;
  ctx_t             x1_ctx_r;
  logic [5:0][63:0] x1_prod_r;
  // helper cross result
  logic   x2_v_r;
  ctx_t   x2_ctx_r;
  vec64_t x2_t_r;
  // Y cross products
  logic             f1_v_r;
  ctx_t             f1_ctx_r;
  vec18_t           f1_ax_r, f1_az_r;
  logic [5:0][35:0] f1_prod_r;
  // Y cross result
  logic   f2_v_r;
  ctx_t   f2_ctx_r;
  vec18_t f2_ax_r, f2_az_r;
  vec32_t f2_ay_r;
  // output register
  logic   out_v_r;
  vec32_t o_org_r, o_ax_r, o_ay_r, o_az_r;

  vec18_t           a1_nxt;
  ctx_t             p_ctx_nxt;
  vec32_t           pa_nxt, pb_nxt;
  logic [16:0]      ymag;
  logic             pole;
  vec18_t           ax_nxt, az_nxt;
  vec32_t           ay_nxt;
  vec32_t           oax_nxt, oay_nxt, oaz_nxt;

  assign en  = !out_v_r || out_chan.ready;
  assign pop = en && !stat.empty;

  ofb_norm u_norm1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (!stat.empty),
    .in_ctx    (head.ctx),
    .in_c      (head.t),
    .out_valid (n1_v),
    .out_ctx   (n1_ctx),
    .out_u     (n1_u),
    .out_nz    (n1_nz)
  );

  always_comb begin
    a1_nxt = '0;
    case (n1_ctx.mode)
      MODE_FACE: a1_nxt = n1_u;
      MODE_EDGE: a1_nxt = n1_nz ? n1_u : {18'd0, 18'd0, ONE_Q16};
      MODE_VIEW: a1_nxt = n1_nz ? n1_u : {ONE_Q16, 18'd0, 18'd0};
      default:   a1_nxt = '0;
    endcase
    p_ctx_nxt    = n1_ctx;
    p_ctx_nxt.a1 = a1_nxt;
    ymag = a1_nxt[1][17] ? 17'(-a1_nxt[1]) : a1_nxt[1][16:0];
    pole = ymag > pole_thr;
    pa_nxt = '0;
    pb_nxt = '0;
    case (n1_ctx.mode)
      MODE_FACE: begin
        pa_nxt = pole ? {32'd0, 32'd0, sx18(ONE_Q16)} : {32'd0, sx18(ONE_Q16), 32'd0};
        pb_nxt = {sx18(a1_nxt[2]), sx18(a1_nxt[1]), sx18(a1_nxt[0])};
      end
      MODE_EDGE: begin
        pa_nxt = {sx18(a1_nxt[2]), sx18(a1_nxt[1]), sx18(a1_nxt[0])};
        pb_nxt = pole ? {sx18(ONE_Q16), 32'd0, 32'd0} : {32'd0, sx18(ONE_Q16), 32'd0};
      end
      MODE_VIEW: begin
        pa_nxt = {sx18(a1_nxt[2]), sx18(a1_nxt[1]), sx18(a1_nxt[0])};
        pb_nxt = n1_ctx.up;
      end
      default: begin
        pa_nxt = '0;
        pb_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r  <= 1'b0;
      x1_v_r <= 1'b0;
      x2_v_r <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      p_v_r  <= n1_v;
      x1_v_r <= p_v_r;
      x2_v_r <= x1_v_r;
      f1_v_r <= n2_v;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ctx_r <= p_ctx_nxt;
      p_a_r   <= pa_nxt;
      p_b_r   <= pb_nxt;

      x1_ctx_r     <= p_ctx_r;
      x1_prod_r[0] <= 64'($signed(p_a_r[1]) * $signed(p_b_r[2]));
      x1_prod_r[1] <= 64'($signed(p_a_r[2]) * $signed(p_b_r[1]));
      x1_prod_r[2] <= 64'($signed(p_a_r[2]) * $signed(p_b_r[0]));
      x1_prod_r[3] <= 64'($signed(p_a_r[0]) * $signed(p_b_r[2]));
      x1_prod_r[4] <= 64'($signed(p_a_r[0]) * $signed(p_b_r[1]));
      x1_prod_r[5] <= 64'($signed(p_a_r[1]) * $signed(p_b_r[0]));

      x2_ctx_r  <= x1_ctx_r;
      x2_t_r[0] <= x1_prod_r[0] - x1_prod_r[1];
      x2_t_r[1] <= x1_prod_r[2] - x1_prod_r[3];
      x2_t_r[2] <= x1_prod_r[4] - x1_prod_r[5];
    end
  end

  ofb_norm u_norm2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x2_v_r),
    .in_ctx    (x2_ctx_r),
    .in_c      (x2_t_r),
    .out_valid (n2_v),
    .out_ctx   (n2_ctx),
    .out_u     (n2_u),
    .out_nz    (n2_nz)
  );

  always_comb begin
    ax_nxt = n2_u;
    az_nxt = n2_ctx.a1;
    case (n2_ctx.mode)
      MODE_EDGE: begin
        ax_nxt = n2_ctx.a1;
        az_nxt = n2_u;
      end
      default: begin
        ax_nxt = n2_nz ? n2_u : '0;
        az_nxt = n2_ctx.a1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ctx_r     <= n2_ctx;
      f1_ax_r      <= ax_nxt;
      f1_az_r      <= az_nxt;
      f1_prod_r[0] <= 36'($signed(az_nxt[1]) * $signed(ax_nxt[2]));
      f1_prod_r[1] <= 36'($signed(az_nxt[2]) * $signed(ax_nxt[1]));
      f1_prod_r[2] <= 36'($signed(az_nxt[2]) * $signed(ax_nxt[0]));
      f1_prod_r[3] <= 36'($signed(az_nxt[0]) * $signed(ax_nxt[2]));
      f1_prod_r[4] <= 36'($signed(az_nxt[0]) * $signed(ax_nxt[1]));
      f1_prod_r[5] <= 36'($signed(az_nxt[1]) * $signed(ax_nxt[0]));
    end
  end

  always_comb begin
    logic signed [36:0] d;
    logic [36:0]        m;
    logic [20:0]        rq;
    for (int i = 0; i < 3; i++) begin
      d  = 37'($signed(f1_prod_r[2*i])) - 37'($signed(f1_prod_r[2*i+1]));
      m  = d[36] ? 37'(-d) : d;
      rq = 21'((m + 37'd32768) >> 16);
      ay_nxt[i] = d[36] ? 32'(-{11'd0, rq}) : {11'd0, rq};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_ctx_r <= f1_ctx_r;
      f2_ax_r  <= f1_ax_r;
      f2_az_r  <= f1_az_r;
      f2_ay_r  <= ay_nxt;
    end
  end

  always_comb begin
    oax_nxt = {sx18(f2_ax_r[2]), sx18(f2_ax_r[1]), sx18(f2_ax_r[0])};
    oay_nxt = f2_ay_r;
    oaz_nxt = {sx18(f2_az_r[2]), sx18(f2_az_r[1]), sx18(f2_az_r[0])};
    case (f2_ctx_r.mode)
      MODE_IDENT: begin
        oax_nxt = {32'd0, 32'd0, sx18(ONE_Q16)};
        oay_nxt = {32'd0, sx18(ONE_Q16), 32'd0};
        oaz_nxt = {sx18(ONE_Q16), 32'd0, 32'd0};
      end
      default: begin
        oax_nxt = {sx18(f2_ax_r[2]), sx18(f2_ax_r[1]), sx18(f2_ax_r[0])};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_org_r <= f2_ctx_r.org;
      o_ax_r  <= oax_nxt;
      o_ay_r  <= oay_nxt;
      o_az_r  <= oaz_nxt;
    end
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.origin_x = o_org_r[0];
  assign out_chan.origin_y = o_org_r[1];
  assign out_chan.origin_z = o_org_r[2];
  assign out_chan.x_axis_x = o_ax_r[0];
  assign out_chan.x_axis_y = o_ax_r[1];
  assign out_chan.x_axis_z = o_ax_r[2];
  assign out_chan.y_axis_x = o_ay_r[0];
  assign out_chan.y_axis_y = o_ay_r[1];
  assign out_chan.y_axis_z = o_ay_r[2];
  assign out_chan.z_axis_x = o_az_r[0];
  assign out_chan.z_axis_y = o_az_r[1];
  assign out_chan.z_axis_z = o_az_r[2];
endmodule
